/* hw/rtl/fmw_pkg.sv */
package fmw_pkg;

   localparam int POS_BITS      = 8;
   localparam int MOTION_BITS   = 9;
   localparam int TARGET_BITS   = MOTION_BITS + 1;
   localparam int PIX_PORT_BITS = 16;
   localparam int DIM_BITS      = 9;
   localparam int CSR_IDX_BITS  = 2;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_PIXEL_BITS = 16;

   localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(256);
   localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(256);

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MASKED_MODE  = 2'd2;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_SCATTER = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef struct packed {
      logic       valid;
      action_type action;
      logic       in_range;
   } stage_ctl_type;

endpackage

/* hw/rtl/forward_motion_warp_unit.sv */
// Forward motion warp over an on-chip frame store.
// Request channel: start with req_* fields, taken when start is high and
// busy is low. busy is never raised, so one word is taken every cycle.
// action 0 loads a base entry, 1 scatters a pixel to position plus motion,
// 2 reads an entry, 3 is ignored.
// Response channel: rsp_valid strobes for one cycle with rsp_pixel_out;
// one response per read, in request order. There is no backpressure.
// A read passes the stage 1 register, the stage 2 register and the response register.
// Throughput: one word per cycle; the store is a single-port-write,
// one-read memory with a three-stage read/modify/write pipe and
// forwarding of the last write into the following read.
// CSR channel: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready
// is always high. Write only while no request is in flight.
// Reset clears the pipe and sets width 256, height 256, plain mode. The
// store contents are not cleared; entries must be loaded before use.
module forward_motion_warp_unit #(
   parameter int MAX_WIDTH  = fmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fmw_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = fmw_pkg::DEF_PIXEL_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_action,
   input  logic [fmw_pkg::POS_BITS-1:0]           req_pos_x,
   input  logic [fmw_pkg::POS_BITS-1:0]           req_pos_y,
   input  logic [fmw_pkg::PIX_PORT_BITS-1:0]      req_pixel_value,
   input  logic                                   req_mask_bit,
   input  logic signed [fmw_pkg::MOTION_BITS-1:0] req_motion_dx,
   input  logic signed [fmw_pkg::MOTION_BITS-1:0] req_motion_dy,
   output logic                                   rsp_valid,
   output logic [fmw_pkg::PIX_PORT_BITS-1:0]      rsp_pixel_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fmw_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [fmw_pkg::DIM_BITS-1:0]           csr_wdata
);
   import fmw_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [DIM_BITS-1:0]   frame_width_ff, frame_width_in;
   logic [DIM_BITS-1:0]   frame_height_ff, frame_height_in;
   logic                  masked_mode_ff, masked_mode_in;
   logic                  accept;

   stage_ctl_type         s1_ctl;
   logic [AW-1:0]         s1_addr;
   logic [PIXEL_BITS-1:0] s1_pixel;
   logic                  s1_mask;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      masked_mode_in  = masked_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            CSR_MASKED_MODE:  masked_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         masked_mode_ff  <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         masked_mode_ff  <= masked_mode_in;
      end
   end

   fmw_addr_gen #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS),
      .AW         (AW)
   ) u_addr_gen (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (action_type'(req_action)),
      .pos_x        (req_pos_x),
      .pos_y        (req_pos_y),
      .pixel_value  (req_pixel_value),
      .mask_bit     (req_mask_bit),
      .motion_dx    (req_motion_dx),
      .motion_dy    (req_motion_dy),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .masked_mode  (masked_mode_ff),
      .s1_ctl       (s1_ctl),
      .s1_addr      (s1_addr),
      .s1_pixel     (s1_pixel),
      .s1_mask      (s1_mask)
   );

   fmw_frame_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS),
      .AW         (AW)
   ) u_frame_store (
      .clock         (clock),
      .reset         (reset),
      .masked_mode   (masked_mode_ff),
      .s1_ctl        (s1_ctl),
      .s1_addr       (s1_addr),
      .s1_pixel      (s1_pixel),
      .s1_mask       (s1_mask),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out)
   );

endmodule

/* hw/rtl/fmw_addr_gen.sv */
module fmw_addr_gen #(
   parameter int MAX_WIDTH  = fmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fmw_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = fmw_pkg::DEF_PIXEL_BITS,
   parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  fmw_pkg::action_type                   action,
   input  logic [fmw_pkg::POS_BITS-1:0]          pos_x,
   input  logic [fmw_pkg::POS_BITS-1:0]          pos_y,
   input  logic [fmw_pkg::PIX_PORT_BITS-1:0]     pixel_value,
   input  logic                                  mask_bit,
   input  logic signed [fmw_pkg::MOTION_BITS-1:0] motion_dx,
   input  logic signed [fmw_pkg::MOTION_BITS-1:0] motion_dy,
   input  logic [fmw_pkg::DIM_BITS-1:0]          frame_width,
   input  logic [fmw_pkg::DIM_BITS-1:0]          frame_height,
   input  logic                                  masked_mode,
   output fmw_pkg::stage_ctl_type                s1_ctl,
   output logic [AW-1:0]                         s1_addr,
   output logic [PIXEL_BITS-1:0]                 s1_pixel,
   output logic                                  s1_mask
);
   import fmw_pkg::*;

   localparam int WUW = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ? $clog2(MAX_WIDTH + 1) : DIM_BITS;
   localparam int HUW = ($clog2(MAX_HEIGHT + 1) > DIM_BITS) ? $clog2(MAX_HEIGHT + 1) : DIM_BITS;

   logic [WUW-1:0]                width_use;
   logic [HUW-1:0]                height_use;
   logic signed [TARGET_BITS-1:0] tx;
   logic signed [TARGET_BITS-1:0] ty;
   logic signed [TARGET_BITS-1:0] off_x;
   logic signed [TARGET_BITS-1:0] off_y;
   logic                          x_ok;
   logic                          y_ok;
   logic                          in_range;
   logic [AW-1:0]                 addr;

   stage_ctl_type                 ctl_ff, ctl_in;
   logic [AW-1:0]                 addr_ff;
   logic [PIXEL_BITS-1:0]         pixel_ff, pixel_in;
   logic                          mask_ff, mask_in;

   always_comb begin
      width_use  = (WUW'(frame_width) > WUW'(MAX_WIDTH)) ? WUW'(MAX_WIDTH) : WUW'(frame_width);
      height_use = (HUW'(frame_height) > HUW'(MAX_HEIGHT)) ? HUW'(MAX_HEIGHT) : HUW'(frame_height);
      off_x = (action == ACT_SCATTER) ? TARGET_BITS'(motion_dx) : '0;
      off_y = (action == ACT_SCATTER) ? TARGET_BITS'(motion_dy) : '0;
      tx = $signed({2'b00, pos_x}) + off_x;
      ty = $signed({2'b00, pos_y}) + off_y;
      x_ok = !tx[TARGET_BITS-1] && (WUW'(tx[TARGET_BITS-2:0]) < width_use);
      y_ok = !ty[TARGET_BITS-1] && (HUW'(ty[TARGET_BITS-2:0]) < height_use);
      in_range = x_ok && y_ok;
      addr = in_range ? (AW'(ty[TARGET_BITS-2:0]) * AW'(MAX_WIDTH) + AW'(tx[TARGET_BITS-2:0]))
                      : '0;
      ctl_in.valid    = accept;
      ctl_in.action   = action;
      ctl_in.in_range = in_range;
      pixel_in = masked_mode ? PIXEL_BITS'(pixel_value) : '0;
      if (action == ACT_LOAD && !masked_mode) begin
         mask_in = 1'b1;
      end else begin
         mask_in = mask_bit;
      end
      if (action == ACT_SCATTER) begin
         pixel_in = PIXEL_BITS'(pixel_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr;
      pixel_ff <= pixel_in;
      mask_ff  <= mask_in;
   end

   assign s1_ctl   = ctl_ff;
   assign s1_addr  = addr_ff;
   assign s1_pixel = pixel_ff;
   assign s1_mask  = mask_ff;

endmodule

/* hw/rtl/fmw_frame_store.sv */
module fmw_frame_store #(
   parameter int MAX_WIDTH  = fmw_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fmw_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = fmw_pkg::DEF_PIXEL_BITS,
   parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              masked_mode,
   input  fmw_pkg::stage_ctl_type            s1_ctl,
   input  logic [AW-1:0]                     s1_addr,
   input  logic [PIXEL_BITS-1:0]             s1_pixel,
   input  logic                              s1_mask,
   output logic                              rsp_valid,
   output logic [fmw_pkg::PIX_PORT_BITS-1:0] rsp_pixel_out
);
   import fmw_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int EW    = PIXEL_BITS + 1;

   // entry: {dest mask, pixel}
   logic [EW-1:0]            mem [DEPTH];
   logic [EW-1:0]            rd_ff;

   stage_ctl_type            s2_ctl_ff;
   logic [AW-1:0]            s2_addr_ff;
   logic [PIXEL_BITS-1:0]    s2_pixel_ff;
   logic                     s2_mask_ff;

   logic                     fwd_ff, fwd_in;
   logic [EW-1:0]            fwd_data_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIX_PORT_BITS-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic [EW-1:0]            cur;
   logic                     cur_mask;
   logic                     is_load;
   logic                     is_scatter;
   logic                     is_read;
   logic                     we;
   logic [EW-1:0]            wdata;

   always_comb begin
      cur        = fwd_ff ? fwd_data_ff : rd_ff;
      cur_mask   = cur[PIXEL_BITS];
      is_load    = s2_ctl_ff.action == ACT_LOAD;
      is_scatter = s2_ctl_ff.action == ACT_SCATTER;
      is_read    = s2_ctl_ff.action == ACT_READ;
      we = s2_ctl_ff.valid && s2_ctl_ff.in_range &&
           (is_load || (is_scatter && (!masked_mode || cur_mask)));
      wdata = is_load ? {s2_mask_ff, s2_pixel_ff} : {cur_mask, s2_pixel_ff};
      // write this cycle collides with the read issued this cycle
      fwd_in = we && (s2_addr_ff == s1_addr);
      rsp_valid_in = s2_ctl_ff.valid && is_read;
      rsp_pixel_in = s2_ctl_ff.in_range ? PIX_PORT_BITS'(cur[PIXEL_BITS-1:0]) : '0;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[s2_addr_ff] <= wdata;
      end
      rd_ff <= mem[s1_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff    <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ctl_ff    <= s1_ctl;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_addr_ff   <= s1_addr;
      s2_pixel_ff  <= s1_pixel;
      s2_mask_ff   <= s1_mask;
      fwd_data_ff  <= wdata;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

`ifndef SYNTHESIS
   a_s2_from_s1: assert property (@(posedge clock) disable iff (reset)
      (s2_ctl_ff.valid && !$past(reset)) |-> $past(s1_ctl.valid))
      else $error("stage 2 word without stage 1 word");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(reset)) |-> $past(s2_ctl_ff.valid && is_read))
      else $error("response without read");

   a_mask_blocks: assert property (@(posedge clock) disable iff (reset)
      (s2_ctl_ff.valid && is_scatter && masked_mode && !cur_mask) |-> !we)
      else $error("scatter written through cleared mask");

   a_plain_load: assert property (@(posedge clock) disable iff (reset)
      (we && is_load && !masked_mode) |-> (wdata == {1'b1, {PIXEL_BITS{1'b0}}}))
      else $error("plain load base not zero with set mask");
`endif

endmodule

/* test/forward_motion_warp_unit_tb.sv */
`timescale 1ns / 1ps

module forward_motion_warp_unit_tb;
   import fmw_pkg::*;

   localparam int STORE_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam int STALL_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int TAIL_CYCLES     = 8;
   localparam int PHASES          = 10;
   localparam int WORDS_PER_PHASE = 125;
   localparam int MAX_PRINTS      = 40;

   typedef struct packed {
      action_type                    act;
      logic [POS_BITS-1:0]           x;
      logic [POS_BITS-1:0]           y;
      logic [PIX_PORT_BITS-1:0]      pix;
      logic                          mbit;
      logic signed [MOTION_BITS-1:0] dx;
      logic signed [MOTION_BITS-1:0] dy;
   } warp_word_type;

   typedef struct packed {
      logic                     is_csr;
      logic [CSR_IDX_BITS-1:0]  csr_idx;
      logic [DIM_BITS-1:0]      csr_val;
      warp_word_type            w;
      logic                     has_exp;
      logic [PIX_PORT_BITS-1:0] exp_pix;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_action;
   logic [POS_BITS-1:0]           req_pos_x;
   logic [POS_BITS-1:0]           req_pos_y;
   logic [PIX_PORT_BITS-1:0]      req_pixel_value;
   logic                          req_mask_bit;
   logic signed [MOTION_BITS-1:0] req_motion_dx;
   logic signed [MOTION_BITS-1:0] req_motion_dy;
   logic                          rsp_valid;
   logic [PIX_PORT_BITS-1:0]      rsp_pixel_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [DIM_BITS-1:0]           csr_wdata;

   forward_motion_warp_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pixel_value (req_pixel_value),
      .req_mask_bit    (req_mask_bit),
      .req_motion_dx   (req_motion_dx),
      .req_motion_dy   (req_motion_dy),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_out   (rsp_pixel_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // shadow frame store
   logic [PIX_PORT_BITS-1:0] frame_pix [STORE_DEPTH];
   bit                       frame_mask [STORE_DEPTH];
   bit                       pix_known [STORE_DEPTH];
   bit                       mask_known [STORE_DEPTH];
   int                       loaded_spots[$];
   int                       written_spots[$];
   logic [DIM_BITS-1:0]      width_reg;
   logic [DIM_BITS-1:0]      height_reg;
   bit                       masked_reg;

   logic [PIX_PORT_BITS-1:0] pending_pixels[$];
   logic [PIX_PORT_BITS-1:0] want_pixel;
   script_row_type           script[$];

   int errors;
   int reads_checked;
   int words_sent;
   int csr_writes;
   int scatters_landed;
   int scatters_dropped;
   int stall_cycles;
   int gap_pct;

   // 0: size picked at random
   int phase_cols   [PHASES] = '{256, 256, 1, 1,   256, 5, 16, 0, 0, 256};
   int phase_rows   [PHASES] = '{256, 256, 1, 256, 1,   4, 16, 0, 0, 256};
   bit phase_masked [PHASES] = '{0,   1,   1, 0,   1,   1, 1,  0, 1, 0};

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic report_mismatch(input string msg);
      if (errors < MAX_PRINTS) begin
         $display("[%0t] MISMATCH: %s", $time, msg);
      end
      errors++;
   endtask

   function automatic int cols_in_use();
      return (int'(width_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
   endfunction

   function automatic int rows_in_use();
      return (int'(height_reg) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
   endfunction

   function automatic bit locate(input int x, input int y, output int addr);
      addr = 0;
      if (x < 0 || y < 0 || x >= cols_in_use() || y >= rows_in_use()) begin
         return 1'b0;
      end
      addr = y * DEF_MAX_WIDTH + x;
      return 1'b1;
   endfunction

   function automatic void scatter_target(input warp_word_type w, output int tx, output int ty);
      tx = int'(w.x) + int'($signed(w.dx));
      ty = int'(w.y) + int'($signed(w.dy));
   endfunction

   function automatic void random_spot(output int x, output int y);
      x = int'($urandom_range(0, cols_in_use() - 1));
      y = int'($urandom_range(0, rows_in_use() - 1));
   endfunction

   // reads of never-written entries and mask tests on never-loaded ones are kept out
   function automatic bit word_is_legal(input warp_word_type w);
      int addr;
      int tx;
      int ty;
      if (w.act == ACT_READ) begin
         if (locate(int'(w.x), int'(w.y), addr)) begin
            return pix_known[addr];
         end
      end else if (w.act == ACT_SCATTER) begin
         scatter_target(w, tx, ty);
         if (masked_reg && locate(tx, ty, addr)) begin
            return mask_known[addr];
         end
      end
      return 1'b1;
   endfunction

   function automatic void apply_word(input warp_word_type w, output bit has_rsp,
                                      output logic [PIX_PORT_BITS-1:0] rsp);
      int addr;
      int tx;
      int ty;
      has_rsp = 1'b0;
      rsp = '0;
      case (w.act)
         ACT_LOAD: begin
            if (locate(int'(w.x), int'(w.y), addr)) begin
               if (!mask_known[addr]) begin
                  loaded_spots.push_back(addr);
               end
               if (!pix_known[addr]) begin
                  written_spots.push_back(addr);
               end
               frame_pix[addr] = masked_reg ? w.pix : '0;
               frame_mask[addr] = masked_reg ? w.mbit : 1'b1;
               pix_known[addr] = 1'b1;
               mask_known[addr] = 1'b1;
            end
         end
         ACT_SCATTER: begin
            scatter_target(w, tx, ty);
            if (locate(tx, ty, addr) && (!masked_reg || frame_mask[addr])) begin
               if (!pix_known[addr]) begin
                  written_spots.push_back(addr);
               end
               frame_pix[addr] = w.pix;
               pix_known[addr] = 1'b1;
               scatters_landed++;
            end else begin
               scatters_dropped++;
            end
         end
         ACT_READ: begin
            has_rsp = 1'b1;
            if (locate(int'(w.x), int'(w.y), addr)) begin
               rsp = frame_pix[addr];
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic warp_word_type random_word();
      warp_word_type w;
      int tries;
      int roll;
      int tx;
      int ty;
      int spot;
      bit ok;
      ok = 1'b0;
      w = '0;
      for (tries = 0; tries < 16 && !ok; tries++) begin
         w.act = ACT_LOAD;
         w.x = POS_BITS'($urandom);
         w.y = POS_BITS'($urandom);
         w.pix = PIX_PORT_BITS'($urandom);
         w.mbit = ($urandom_range(0, 3) != 0);
         w.dx = MOTION_BITS'($urandom);
         w.dy = MOTION_BITS'($urandom);
         roll = int'($urandom_range(0, 99));
         if (roll < 34) begin
            if (roll < 29) begin
               random_spot(tx, ty);
               w.x = POS_BITS'(tx);
               w.y = POS_BITS'(ty);
            end
         end else if (roll < 70) begin
            w.act = ACT_SCATTER;
            if (roll < 58) begin
               if (masked_reg && tries % 2 == 0 && loaded_spots.size() != 0) begin
                  spot = loaded_spots[$urandom_range(0, loaded_spots.size() - 1)];
                  tx = spot % DEF_MAX_WIDTH;
                  ty = spot / DEF_MAX_WIDTH;
               end else begin
                  random_spot(tx, ty);
               end
               w.dx = MOTION_BITS'(tx - int'(w.x));
               w.dy = MOTION_BITS'(ty - int'(w.y));
            end
         end else if (roll < 95) begin
            w.act = ACT_READ;
            if (roll < 91) begin
               if (tries % 2 == 0 && written_spots.size() != 0) begin
                  spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
                  tx = spot % DEF_MAX_WIDTH;
                  ty = spot / DEF_MAX_WIDTH;
               end else begin
                  random_spot(tx, ty);
               end
               w.x = POS_BITS'(tx);
               w.y = POS_BITS'(ty);
            end
         end else begin
            w.act = ACT_NONE;
         end
         ok = word_is_legal(w);
      end
      if (!ok) begin
         w.act = ACT_LOAD;
         random_spot(tx, ty);
         w.x = POS_BITS'(tx);
         w.y = POS_BITS'(ty);
      end
      return w;
   endfunction

   function automatic void add_word(input action_type act, input int x, input int y,
                                    input int pix, input int m, input int dx, input int dy,
                                    input int has, input int want);
      script_row_type row;
      row = '0;
      row.w.act = act;
      row.w.x = POS_BITS'(x);
      row.w.y = POS_BITS'(y);
      row.w.pix = PIX_PORT_BITS'(pix);
      row.w.mbit = (m != 0);
      row.w.dx = MOTION_BITS'(dx);
      row.w.dy = MOTION_BITS'(dy);
      row.has_exp = (has != 0);
      row.exp_pix = PIX_PORT_BITS'(want);
      script.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_BITS-1:0] idx, input int val);
      script_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = DIM_BITS'(val);
      script.push_back(row);
   endfunction

   function automatic void build_script();
      // plain mode, full frame
      add_word(ACT_LOAD,      0,   0, 'hFFFF, 0,    0,    0, 0, 0);
      add_word(ACT_READ,      0,   0, 0,      0,    0,    0, 1, 0);
      add_word(ACT_LOAD,    255, 255, 'h1234, 1,    0,    0, 0, 0);
      add_word(ACT_SCATTER,   0,   0, 'hFFFF, 0,  255,  255, 0, 0);
      add_word(ACT_READ,    255, 255, 0,      0,    0,    0, 1, 'hFFFF);
      add_word(ACT_SCATTER, 255, 255, 'h1234, 1, -256, -256, 0, 0);
      add_word(ACT_SCATTER, 255, 255, 'hA5A5, 0, -255, -255, 0, 0);
      add_word(ACT_READ,      0,   0, 0,      0,    0,    0, 1, 'hA5A5);
      add_word(ACT_NONE,      0,   0, 'hFFFF, 1,  255,  255, 0, 0);
      // masked mode, 4 x 3 frame
      add_csr(CSR_MASKED_MODE, 1);
      add_csr(CSR_FRAME_WIDTH, 4);
      add_csr(CSR_FRAME_HEIGHT, 3);
      add_word(ACT_LOAD,      3,   2, 'h8001, 0,    0,    0, 0, 0);
      add_word(ACT_LOAD,      1,   1, 'h0000, 1,    0,    0, 0, 0);
      add_word(ACT_SCATTER,   0,   0, 'h7777, 1,    3,    2, 0, 0);
      add_word(ACT_READ,      3,   2, 0,      0,    0,    0, 1, 'h8001);
      add_word(ACT_SCATTER, 200, 100, 'hBEEF, 0, -199,  -99, 0, 0);
      add_word(ACT_READ,      1,   1, 0,      0,    0,    0, 1, 'hBEEF);
      add_word(ACT_LOAD,      4,   0, 'h5555, 1,    0,    0, 0, 0);
      add_word(ACT_READ,      4,   0, 0,      0,    0,    0, 1, 0);
      add_word(ACT_READ,      0,   3, 0,      0,    0,    0, 1, 0);
      // back to plain: stored mask is ignored
      add_csr(CSR_MASKED_MODE, 0);
      add_word(ACT_SCATTER,   3,   2, 'h1111, 0,    0,    0, 0, 0);
      add_word(ACT_READ,      3,   2, 0,      0,    0,    0, 1, 'h1111);
      // zero width: nothing in frame
      add_csr(CSR_FRAME_WIDTH, 0);
      add_word(ACT_READ,      0,   0, 0,      0,    0,    0, 1, 0);
      add_word(ACT_LOAD,      0,   0, 'hFFFF, 1,    0,    0, 0, 0);
      // oversize dimensions clamp to the store
      add_csr(CSR_FRAME_WIDTH, 511);
      add_csr(CSR_FRAME_HEIGHT, 300);
      add_csr(CSR_MASKED_MODE, 'h1FF);
      add_word(ACT_READ,    255, 255, 0,      0,    0,    0, 1, 'hFFFF);
      add_word(ACT_SCATTER, 255,   0, 'h4242, 0,    0,  255, 0, 0);
      add_word(ACT_READ,    255, 255, 0,      0,    0,    0, 1, 'h4242);
   endfunction

   task automatic send_word(input warp_word_type w, input bit typed,
                            input logic [PIX_PORT_BITS-1:0] typed_pix);
      bit has_rsp;
      logic [PIX_PORT_BITS-1:0] rsp;
      while ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_action <= w.act;
      req_pos_x <= w.x;
      req_pos_y <= w.y;
      req_pixel_value <= w.pix;
      req_mask_bit <= w.mbit;
      req_motion_dx <= w.dx;
      req_motion_dy <= w.dy;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      apply_word(w, has_rsp, rsp);
      if (has_rsp) begin
         pending_pixels.push_back(typed ? typed_pix : rsp);
      end
      words_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [DIM_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_FRAME_WIDTH:  width_reg = val;
         CSR_FRAME_HEIGHT: height_reg = val;
         CSR_MASKED_MODE:  masked_reg = val[0];
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word, pixel_out %h", rsp_pixel_out));
         end else begin
            want_pixel = pending_pixels.pop_front();
            reads_checked++;
            if (rsp_pixel_out !== want_pixel) begin
               report_mismatch($sformatf("pixel_out %h, expected %h",
                                         rsp_pixel_out, want_pixel));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int cols;
      int rows;
      reset = 1'b1;
      start = 1'b0;
      req_action = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pixel_value = '0;
      req_mask_bit = 1'b0;
      req_motion_dx = '0;
      req_motion_dy = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      gap_pct = 36;
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      masked_reg = 1'b0;
      build_script();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            settle();
            write_csr(script[i].csr_idx, script[i].csr_val);
         end else begin
            send_word(script[i].w, script[i].has_exp, script[i].exp_pix);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         gap_pct = (p == 1) ? 0 : 36;
         cols = (phase_cols[p] == 0) ? int'($urandom_range(2, 48)) : phase_cols[p];
         rows = (phase_rows[p] == 0) ? int'($urandom_range(2, 48)) : phase_rows[p];
         write_csr(CSR_FRAME_WIDTH, DIM_BITS'(cols));
         write_csr(CSR_FRAME_HEIGHT, DIM_BITS'(rows));
         write_csr(CSR_MASKED_MODE, DIM_BITS'(phase_masked[p]));
         repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         report_mismatch($sformatf("%0d reads never answered", pending_pixels.size()));
      end
      $display("Sent %0d request words under %0d register writes, plain and masked frames.",
               words_sent, csr_writes);
      $display("Compared %0d reads; %0d scatters landed, %0d fell off frame or mask.",
               reads_checked, scatters_landed, scatters_dropped);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
